// File: rtl/psq_pkg.sv
// Package with shared types and constants for the precharge relay sequencer.
package psq_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_NUM     = 6;
	localparam int unsigned CFG_W       = 16;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRE_ON_DLY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_ON_DLY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRE_OFF_DLY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEG_OFF_DLY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_TMO      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_TMO     = 3'd5;

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0] CFG_PRE_ON_DLY_RST  = 16'd10;
	localparam logic [CFG_W-1:0] CFG_POS_ON_DLY_RST  = 16'd50;
	localparam logic [CFG_W-1:0] CFG_PRE_OFF_DLY_RST = 16'd10;
	localparam logic [CFG_W-1:0] CFG_NEG_OFF_DLY_RST = 16'd10;
	localparam logic [CFG_W-1:0] CFG_ON_TMO_RST      = 16'd500;
	localparam logic [CFG_W-1:0] CFG_OFF_TMO_RST     = 16'd500;

	// Counter slots
	localparam int unsigned CNT_NUM    = 6;
	localparam int unsigned CNT_PRE_ON  = 0;
	localparam int unsigned CNT_POS_ON  = 1;
	localparam int unsigned CNT_PRE_OFF = 2;
	localparam int unsigned CNT_NEG_OFF = 3;
	localparam int unsigned CNT_ON_TMR  = 4;
	localparam int unsigned CNT_OFF_TMR = 5;

	typedef enum logic [2:0] {
		MODE_INIT    = 3'd0,
		MODE_STANDBY = 3'd1,
		MODE_READY   = 3'd2,
		MODE_ON      = 3'd3,
		MODE_OFF     = 3'd4,
		MODE_PROTECT = 3'd5
	} mode_t;

	// Drive and status bits carried between the state register and step logic
	typedef struct packed {
		logic drv_neg;
		logic drv_pre;
		logic drv_pos;
		logic pre_closed;
		logic on_done;
		logic off_done;
		logic fb_fault;
		logic on_fault;
		logic off_fault;
	} flags_t;

	localparam flags_t FLAGS_CLEAR = '0;

endpackage

// File: rtl/psq_step.sv
// Next-state logic of the sequencer for one tick.
module psq_step import psq_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  mode_t                                  mode_cur,
	input  flags_t                                 flags_cur,
	input  logic [CNT_NUM-1:0][COUNT_WIDTH-1:0]    cnt_cur,
	input  logic [CFG_NUM-1:0][CFG_W-1:0]          cfg,
	input  logic                                   wake,
	input  logic                                   pos_fb,
	input  logic                                   neg_fb,
	output mode_t                                  mode_nxt,
	output flags_t                                 flags_nxt,
	output logic [CNT_NUM-1:0][COUNT_WIDTH-1:0]    cnt_nxt
);

	localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	// counter >= threshold, both zero-extended to a common width
	function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
	                                 input logic [CFG_W-1:0] t);
		return CMP_W'(c) >= CMP_W'(t);
	endfunction

	always_comb begin
		mode_nxt  = mode_cur;
		flags_nxt = flags_cur;
		cnt_nxt   = cnt_cur;
		unique case (mode_cur)
			MODE_INIT: begin
				flags_nxt = FLAGS_CLEAR;
				cnt_nxt   = '0;
				mode_nxt  = MODE_STANDBY;
			end
			MODE_STANDBY: begin
				// stuck contact while everything should be open
				if (pos_fb || neg_fb) begin
					flags_nxt.fb_fault   = 1'b1;
					flags_nxt.drv_neg    = 1'b0;
					flags_nxt.drv_pre    = 1'b0;
					flags_nxt.drv_pos    = 1'b0;
					flags_nxt.pre_closed = 1'b0;
					mode_nxt             = MODE_PROTECT;
				end else begin
					mode_nxt = MODE_READY;
				end
			end
			MODE_READY: begin
				cnt_nxt            = '0;
				flags_nxt.on_done  = 1'b0;
				flags_nxt.off_done = 1'b0;
				if (wake)
					mode_nxt = MODE_ON;
			end
			MODE_ON: begin
				cnt_nxt[CNT_NEG_OFF] = '0;
				cnt_nxt[CNT_OFF_TMR] = '0;
				flags_nxt.on_done    = 1'b0;
				flags_nxt.off_done   = 1'b0;
				flags_nxt.drv_neg    = 1'b1;
				// phases evaluated in order, each sees the previous one's update
				if (neg_fb && !flags_nxt.pre_closed && !pos_fb) begin
					cnt_nxt[CNT_PRE_ON] = sat_inc(cnt_cur[CNT_PRE_ON]);
					if (reached(cnt_nxt[CNT_PRE_ON], cfg[CFG_PRE_ON_DLY])) begin
						flags_nxt.drv_pre    = 1'b1;
						flags_nxt.pre_closed = 1'b1;
					end
				end
				if (neg_fb && flags_nxt.pre_closed && !pos_fb) begin
					cnt_nxt[CNT_POS_ON] = sat_inc(cnt_cur[CNT_POS_ON]);
					if (reached(cnt_nxt[CNT_POS_ON], cfg[CFG_POS_ON_DLY]))
						flags_nxt.drv_pos = 1'b1;
				end
				if (neg_fb && flags_nxt.pre_closed && pos_fb) begin
					cnt_nxt[CNT_PRE_OFF] = sat_inc(cnt_cur[CNT_PRE_OFF]);
					if (reached(cnt_nxt[CNT_PRE_OFF], cfg[CFG_PRE_OFF_DLY])) begin
						flags_nxt.drv_pre    = 1'b0;
						flags_nxt.pre_closed = 1'b0;
					end
				end
				if (neg_fb && !flags_nxt.pre_closed && pos_fb) begin
					flags_nxt.drv_pos = 1'b1;
					flags_nxt.on_done = 1'b1;
				end
				if (!flags_nxt.on_done)
					cnt_nxt[CNT_ON_TMR] = sat_inc(cnt_cur[CNT_ON_TMR]);
				// timeout wins over wake falling
				if (CMP_W'(cnt_nxt[CNT_ON_TMR]) > CMP_W'(cfg[CFG_ON_TMO])) begin
					flags_nxt.on_fault   = 1'b1;
					flags_nxt.on_done    = 1'b0;
					flags_nxt.drv_neg    = 1'b0;
					flags_nxt.drv_pre    = 1'b0;
					flags_nxt.drv_pos    = 1'b0;
					flags_nxt.pre_closed = 1'b0;
					mode_nxt             = MODE_PROTECT;
				end else if (!wake) begin
					mode_nxt = MODE_OFF;
				end
			end
			MODE_OFF: begin
				cnt_nxt[CNT_PRE_ON]  = '0;
				cnt_nxt[CNT_POS_ON]  = '0;
				cnt_nxt[CNT_PRE_OFF] = '0;
				flags_nxt.off_done   = 1'b0;
				flags_nxt.on_done    = 1'b0;
				flags_nxt.drv_pos    = 1'b0;
				if (neg_fb && !flags_cur.pre_closed) begin
					cnt_nxt[CNT_NEG_OFF] = sat_inc(cnt_cur[CNT_NEG_OFF]);
					if (reached(cnt_nxt[CNT_NEG_OFF], cfg[CFG_NEG_OFF_DLY])) begin
						flags_nxt.drv_neg    = 1'b0;
						flags_nxt.drv_pre    = 1'b0;
						flags_nxt.pre_closed = 1'b0;
						flags_nxt.off_done   = 1'b1;
					end
				end
				cnt_nxt[CNT_OFF_TMR] = sat_inc(cnt_cur[CNT_OFF_TMR]);
				// timeout wins over both contacts open
				if (CMP_W'(cnt_nxt[CNT_OFF_TMR]) > CMP_W'(cfg[CFG_OFF_TMO])) begin
					flags_nxt.off_fault  = 1'b1;
					flags_nxt.drv_neg    = 1'b0;
					flags_nxt.drv_pre    = 1'b0;
					flags_nxt.drv_pos    = 1'b0;
					flags_nxt.pre_closed = 1'b0;
					mode_nxt             = MODE_PROTECT;
				end else if (!pos_fb && !neg_fb) begin
					mode_nxt = MODE_READY;
				end
			end
			default: begin
				// protect, and any unused code: everything open
				flags_nxt.drv_neg    = 1'b0;
				flags_nxt.drv_pre    = 1'b0;
				flags_nxt.drv_pos    = 1'b0;
				flags_nxt.pre_closed = 1'b0;
				mode_nxt             = MODE_PROTECT;
			end
		endcase
	end

endmodule

// File: rtl/precharge_relay_sequencer_core.sv
// Top level of the precharge relay sequencer: stream ports, state and result registers.
//
// Usage:
//   One transaction on the s_axis side is one control tick carrying the wake
//   request and the two contactor feedbacks. Each tick yields exactly one
//   transaction on the m_axis side with the three coil drives, the done and
//   fault flags and the current mode, all showing the state after the tick.
//   A tick accepted at one edge is presented on m_axis from the next cycle.
//   Throughput is one tick per cycle while m_axis_tready is high; the sequencer
//   state update and the result register are written in the same cycle.
//   The output register is the only buffer: s_tready is high when it is
//   empty or being drained, so a stalled receiver holds the result and
//   back-pressures the input without losing or repeating anything.
//   Configuration registers (delays and timeouts, in ticks) are written
//   through cfg_wr_en / cfg_addr / cfg_wdata, by the user only while the block
//   is idle (the block itself does not enforce this); indexes beyond the last register are ignored.
//   Reset (arst_n low) returns the mode to init, clears all counters, drives
//   and flags, empties the output register and restores register defaults.
//   After a timeout or a stuck feedback the block stays in protect with all
//   contactors open until the next reset.
module precharge_relay_sequencer_core import psq_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// input ticks
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // wake_enable, positive_feedback,
	                                            // negative_feedback, zero pad
	// results
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [15:0]          m_axis_tdata   // negative_drive, precharge_drive,
	                                            // positive_drive, on_done, off_done,
	                                            // feedback_fault, on_timeout_fault,
	                                            // off_timeout_fault, mode[2:0], zero pad
);

	logic [CFG_NUM-1:0][CFG_W-1:0]       cfg_q;
	mode_t                               mode_q, mode_nxt;
	flags_t                              flags_q, flags_nxt;
	logic [CNT_NUM-1:0][COUNT_WIDTH-1:0] cnt_q, cnt_nxt;
	logic                                out_valid_q;
	logic [10:0]                         out_data_q;
	logic                                in_xfer;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[CFG_PRE_ON_DLY]  <= CFG_PRE_ON_DLY_RST;
			cfg_q[CFG_POS_ON_DLY]  <= CFG_POS_ON_DLY_RST;
			cfg_q[CFG_PRE_OFF_DLY] <= CFG_PRE_OFF_DLY_RST;
			cfg_q[CFG_NEG_OFF_DLY] <= CFG_NEG_OFF_DLY_RST;
			cfg_q[CFG_ON_TMO]      <= CFG_ON_TMO_RST;
			cfg_q[CFG_OFF_TMO]     <= CFG_OFF_TMO_RST;
		end else if (cfg_wr_en && (cfg_addr <= CFG_OFF_TMO)) begin
			cfg_q[cfg_addr] <= cfg_wdata;
		end
	end

	psq_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.mode_cur  (mode_q),
		.flags_cur (flags_q),
		.cnt_cur   (cnt_q),
		.cfg       (cfg_q),
		.wake      (s_axis_tdata[0]),
		.pos_fb    (s_axis_tdata[1]),
		.neg_fb    (s_axis_tdata[2]),
		.mode_nxt  (mode_nxt),
		.flags_nxt (flags_nxt),
		.cnt_nxt   (cnt_nxt)
	);

	// Sequencer state, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_INIT;
			flags_q <= FLAGS_CLEAR;
			cnt_q   <= '0;
		end else if (in_xfer) begin
			mode_q  <= mode_nxt;
			flags_q <= flags_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_data_q <= {mode_nxt,
			               flags_nxt.off_fault,
			               flags_nxt.on_fault,
			               flags_nxt.fb_fault,
			               flags_nxt.off_done,
			               flags_nxt.on_done && (mode_nxt == MODE_ON),
			               flags_nxt.drv_pos,
			               flags_nxt.drv_pre,
			               flags_nxt.drv_neg};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_data_q};

	// Protect mode is final until reset
	a_protect_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_PROTECT) |=> (mode_q == MODE_PROTECT))
		else $error("protect mode left without reset");

	// Protect mode never drives a coil
	a_protect_open: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_PROTECT) |-> (!flags_q.drv_neg && !flags_q.drv_pre && !flags_q.drv_pos))
		else $error("coil driven in protect mode");

	// Positive contactor is only driven with the negative one
	a_pos_needs_neg: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.drv_pos |-> flags_q.drv_neg)
		else $error("positive drive without negative drive");

	// State only moves on an accepted tick
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_xfer |=> ($stable(mode_q) && $stable(flags_q)))
		else $error("state changed without an accepted tick");

endmodule
